FILE: hdl/hfsc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the hashed frame slot cache.
package hfsc_pkg;

  typedef struct packed {
    logic [31:0] frame_address;
    logic [15:0] frame_bytes;
  } in_item_t;

  typedef struct packed {
    logic [2:0] slot_index;
    logic       was_hit;
    logic [1:0] status;
  } out_item_t;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
  localparam logic [1:0] STATUS_ADDR_ZERO = 2'd2;

  localparam logic [15:0] CAP_RESET = 16'd5120;
  localparam logic [31:0] HASH_MULT = 32'h045d9f3b;

endpackage

FILE: hdl/hfsc_hash.sv
`timescale 1ns / 1ps
// Multi-cycle home bucket hash: mix, multiply and a compare-and-subtract fold into the bucket range.
module hfsc_hash #(
  parameter int BUCKET_COUNT = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            go,
  input  logic [31:0]                     key,
  output logic                            done,
  output logic [$clog2(BUCKET_COUNT)-1:0] home
);

  localparam int BW = $clog2(BUCKET_COUNT);

  localparam logic [1:0] H_IDLE = 2'd0;
  localparam logic [1:0] H_MUL  = 2'd1;
  localparam logic [1:0] H_MIX  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [31:0]   k_r, k_nxt;
  logic [31:0]   m_r, m_nxt;
  logic          done_r, done_nxt;
  logic [BW-1:0] home_r, home_nxt;
  logic [31:0]   kx;
  logic [31:0]   mx;
  logic [BW:0]   fold;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    m_nxt     = m_r;
    done_nxt  = 1'b0;
    home_nxt  = home_r;
    kx        = k_r ^ (k_r >> 16);
    mx        = m_r ^ (m_r >> 16);
    fold      = {1'b0, mx[BW-1:0]};
    if (fold >= (BW+1)'(BUCKET_COUNT)) begin
      fold = fold - (BW+1)'(BUCKET_COUNT);
    end
    unique case (state_r)
      H_IDLE: begin
        if (go) begin
          k_nxt     = key;
          state_nxt = H_MUL;
        end
      end
      H_MUL: begin
        m_nxt     = kx * hfsc_pkg::HASH_MULT;
        state_nxt = H_MIX;
      end
      H_MIX: begin
        home_nxt  = fold[BW-1:0];
        done_nxt  = 1'b1;
        state_nxt = H_IDLE;
      end
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    m_r    <= m_nxt;
    home_r <= home_nxt;
  end

  assign done = done_r;
  assign home = home_r;

endmodule

FILE: hdl/hfsc_bucket_mem.sv
`timescale 1ns / 1ps
// Bucket store: entry memory with registered read and per-bucket occupied flags.
module hfsc_bucket_mem #(
  parameter int BUCKET_COUNT = 16,
  parameter int SLOT_COUNT   = 8,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [$clog2(BUCKET_COUNT)-1:0] rd_addr,
  output logic                            rd_vld,
  output logic [ADDRESS_BITS-1:0]         rd_key,
  output logic [$clog2(SLOT_COUNT)-1:0]   rd_slot,
  output logic [$clog2(BUCKET_COUNT)-1:0] rd_home,
  input  logic                            wr_en,
  input  logic [$clog2(BUCKET_COUNT)-1:0] wr_addr,
  input  logic [ADDRESS_BITS-1:0]         wr_key,
  input  logic [$clog2(SLOT_COUNT)-1:0]   wr_slot,
  input  logic [$clog2(BUCKET_COUNT)-1:0] wr_home,
  input  logic                            clr_en,
  input  logic [$clog2(BUCKET_COUNT)-1:0] clr_addr
);

  localparam int BW = $clog2(BUCKET_COUNT);
  localparam int SW = $clog2(SLOT_COUNT);
  localparam int EW = ADDRESS_BITS + SW + BW;

  logic [EW-1:0]           mem [BUCKET_COUNT];
  logic [BUCKET_COUNT-1:0] vld_r;
  logic                    rd_vld_r;
  logic [EW-1:0]           rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (clr_en) begin
        vld_r[clr_addr] <= 1'b0;
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_key, wr_slot, wr_home};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_vld  = rd_vld_r;
  assign rd_key  = rd_data_r[EW-1 -: ADDRESS_BITS];
  assign rd_slot = rd_data_r[BW +: SW];
  assign rd_home = rd_data_r[BW-1:0];

endmodule

FILE: hdl/hashed_frame_slot_cache_core.sv
`timescale 1ns / 1ps
// Top level of the hashed frame slot cache: probe sequencer, slot owners and result register.
//
//   channel  | ports                      | handshake
//   ---------+----------------------------+-----------------------------------
//   request  | start, busy, in_item       | taken when start is high, busy low
//   result   | out_strobe, out_item       | one-cycle strobe, no back pressure
//   config   | cfg_valid, cfg_ready, cfg_data | written when valid and ready
//
// One item is worked on at a time; busy stays high until its result is shown.
// A zero address answers in the cycle after the request. Otherwise a lookup runs
// the hash and then probes buckets from the home bucket on; a miss that evicts
// adds a second hash, the search for the old address, a scan of the buckets
// after it to shift entries back, and the insert probe. Reset is synchronous and
// needs no clearing pass. Results cannot be stalled.
module hashed_frame_slot_cache_core #(
  parameter int SLOT_COUNT   = 8,
  parameter int BUCKET_COUNT = 16,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  hfsc_pkg::in_item_t   in_item,
  output logic                 out_strobe,
  output hfsc_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);

  localparam int BW = $clog2(BUCKET_COUNT);
  localparam int SW = $clog2(SLOT_COUNT);
  localparam int AW = ADDRESS_BITS;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_HASHA    = 3'd1;
  localparam logic [2:0] S_PROBE_RD = 3'd2;
  localparam logic [2:0] S_PROBE    = 3'd3;
  localparam logic [2:0] S_OWN      = 3'd4;
  localparam logic [2:0] S_HASHO    = 3'd5;
  localparam logic [2:0] S_SHIFT    = 3'd6;

  localparam logic [1:0] M_FIND  = 2'd0;
  localparam logic [1:0] M_RFIND = 2'd1;
  localparam logic [1:0] M_INS   = 2'd2;

  logic [2:0]          state_r, state_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic [AW-1:0]       key_r, key_nxt;
  logic [AW-1:0]       pk_r, pk_nxt;
  logic [15:0]         bytes_r, bytes_nxt;
  logic [15:0]         cap_r, cap_nxt;
  logic [BW-1:0]       ha_r, ha_nxt;
  logic [BW-1:0]       p_r, p_nxt;
  logic [BW-1:0]       i_r, i_nxt;
  logic [BW-1:0]       hole_r, hole_nxt;
  logic [SW-1:0]       slot_r, slot_nxt;
  logic [SW-1:0]       victim_r, victim_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  hfsc_pkg::out_item_t out_item_r, out_item_nxt;

  logic [AW-1:0]       owner_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] owner_vld_r;
  logic [AW-1:0]       owner_rd_r;
  logic                owner_rdv_r;
  logic                own_we;

  logic                hash_go;
  logic [31:0]         hash_key;
  logic                hash_done;
  logic [BW-1:0]       hash_home;

  logic [BW-1:0]       rd_addr;
  logic                rd_vld;
  logic [AW-1:0]       rd_key;
  logic [SW-1:0]       rd_slot;
  logic [BW-1:0]       rd_home;
  logic                wr_en;
  logic [BW-1:0]       wr_addr;
  logic [AW-1:0]       wr_key;
  logic [SW-1:0]       wr_slot;
  logic [BW-1:0]       wr_home;
  logic                clr_en;
  logic [BW-1:0]       clr_addr;

  logic [AW-1:0]       in_addr;
  logic                match;
  logic                last;
  logic [BW-1:0]       p_inc;
  logic                ins_start;

  function automatic logic [2:0] to_out_slot(input logic [SW-1:0] s);
    logic [SW+2:0] t;
    t = {3'b000, s};
    return t[2:0];
  endfunction

  function automatic logic [BW-1:0] probe_dist(input logic [BW-1:0] x,
                                               input logic [BW-1:0] h);
    logic [BW:0] d;
    d = {1'b0, x} + (BW+1)'(BUCKET_COUNT) - {1'b0, h};
    if (d >= (BW+1)'(BUCKET_COUNT)) begin
      d = d - (BW+1)'(BUCKET_COUNT);
    end
    return d[BW-1:0];
  endfunction

  hfsc_hash #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) u_hash (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (hash_go),
    .key  (hash_key),
    .done (hash_done),
    .home (hash_home)
  );

  hfsc_bucket_mem #(
    .BUCKET_COUNT(BUCKET_COUNT),
    .SLOT_COUNT  (SLOT_COUNT),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_bucket_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_vld  (rd_vld),
    .rd_key  (rd_key),
    .rd_slot (rd_slot),
    .rd_home (rd_home),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_slot (wr_slot),
    .wr_home (wr_home),
    .clr_en  (clr_en),
    .clr_addr(clr_addr)
  );

  assign in_addr = in_item.frame_address[AW-1:0];
  assign match   = rd_vld && (rd_key == pk_r);
  assign last    = (i_r == BW'(BUCKET_COUNT - 1));
  assign p_inc   = (p_r == BW'(BUCKET_COUNT - 1)) ? '0 : p_r + BW'(1);

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    pk_nxt         = pk_r;
    bytes_nxt      = bytes_r;
    cap_nxt        = (cfg_valid && cfg_ready) ? cfg_data : cap_r;
    ha_nxt         = ha_r;
    p_nxt          = p_r;
    i_nxt          = i_r;
    hole_nxt       = hole_r;
    slot_nxt       = slot_r;
    victim_nxt     = victim_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    hash_go        = 1'b0;
    hash_key       = 32'(key_r);
    rd_addr        = p_r;
    wr_en          = 1'b0;
    wr_addr        = p_r;
    wr_key         = key_r;
    wr_slot        = slot_r;
    wr_home        = ha_r;
    clr_en         = 1'b0;
    clr_addr       = p_r;
    own_we         = 1'b0;
    ins_start      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt   = in_addr;
          bytes_nxt = in_item.frame_bytes;
          if (in_addr == '0) begin
            out_strobe_nxt = 1'b1;
            out_item_nxt   = '{slot_index: 3'd0, was_hit: 1'b0,
                               status: hfsc_pkg::STATUS_ADDR_ZERO};
          end else begin
            hash_go   = 1'b1;
            hash_key  = 32'(in_addr);
            state_nxt = S_HASHA;
          end
        end
      end
      S_HASHA: begin
        if (hash_done) begin
          ha_nxt    = hash_home;
          p_nxt     = hash_home;
          i_nxt     = '0;
          pk_nxt    = key_r;
          mode_nxt  = M_FIND;
          state_nxt = S_PROBE_RD;
        end
      end
      S_PROBE_RD: begin
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        unique case (mode_r)
          M_FIND: begin
            if (match) begin
              out_strobe_nxt = 1'b1;
              out_item_nxt   = '{slot_index: to_out_slot(rd_slot), was_hit: 1'b1,
                                 status: hfsc_pkg::STATUS_OK};
              state_nxt      = S_IDLE;
            end else if (!rd_vld || last) begin
              if (bytes_r > cap_r) begin
                out_strobe_nxt = 1'b1;
                out_item_nxt   = '{slot_index: 3'd0, was_hit: 1'b0,
                                   status: hfsc_pkg::STATUS_TOO_LARGE};
                state_nxt      = S_IDLE;
              end else begin
                slot_nxt   = victim_r;
                victim_nxt = (victim_r == SW'(SLOT_COUNT - 1)) ? '0 : victim_r + SW'(1);
                state_nxt  = S_OWN;
              end
            end else begin
              p_nxt   = p_inc;
              i_nxt   = i_r + BW'(1);
              rd_addr = p_inc;
            end
          end
          M_RFIND: begin
            if (match) begin
              clr_en    = 1'b1;
              clr_addr  = p_r;
              hole_nxt  = p_r;
              p_nxt     = p_inc;
              i_nxt     = BW'(1);
              rd_addr   = p_inc;
              state_nxt = S_SHIFT;
            end else if (!rd_vld || last) begin
              ins_start = 1'b1;
            end else begin
              p_nxt   = p_inc;
              i_nxt   = i_r + BW'(1);
              rd_addr = p_inc;
            end
          end
          M_INS: begin
            if (match || !rd_vld || last) begin
              wr_en          = match || !rd_vld;
              own_we         = 1'b1;
              out_strobe_nxt = 1'b1;
              out_item_nxt   = '{slot_index: to_out_slot(slot_r), was_hit: 1'b0,
                                 status: hfsc_pkg::STATUS_OK};
              state_nxt      = S_IDLE;
            end else begin
              p_nxt   = p_inc;
              i_nxt   = i_r + BW'(1);
              rd_addr = p_inc;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_OWN: begin
        if (owner_rdv_r) begin
          pk_nxt    = owner_rd_r;
          hash_go   = 1'b1;
          hash_key  = 32'(owner_rd_r);
          state_nxt = S_HASHO;
        end else begin
          ins_start = 1'b1;
        end
      end
      S_HASHO: begin
        if (hash_done) begin
          p_nxt     = hash_home;
          i_nxt     = '0;
          mode_nxt  = M_RFIND;
          state_nxt = S_PROBE_RD;
        end
      end
      S_SHIFT: begin
        if (!rd_vld) begin
          ins_start = 1'b1;
        end else begin
          if (probe_dist(hole_r, rd_home) < probe_dist(p_r, rd_home)) begin
            wr_en    = 1'b1;
            wr_addr  = hole_r;
            wr_key   = rd_key;
            wr_slot  = rd_slot;
            wr_home  = rd_home;
            clr_en   = 1'b1;
            clr_addr = p_r;
            hole_nxt = p_r;
          end
          if (last) begin
            ins_start = 1'b1;
          end else begin
            p_nxt   = p_inc;
            i_nxt   = i_r + BW'(1);
            rd_addr = p_inc;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (ins_start) begin
      p_nxt     = ha_r;
      i_nxt     = '0;
      pk_nxt    = key_r;
      mode_nxt  = M_INS;
      state_nxt = S_PROBE_RD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= M_FIND;
      cap_r        <= hfsc_pkg::CAP_RESET;
      victim_r     <= '0;
      out_strobe_r <= 1'b0;
      owner_vld_r  <= '0;
      owner_rdv_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      cap_r        <= cap_nxt;
      victim_r     <= victim_nxt;
      out_strobe_r <= out_strobe_nxt;
      owner_rdv_r  <= owner_vld_r[victim_r];
      if (own_we) begin
        owner_vld_r[slot_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    pk_r       <= pk_nxt;
    bytes_r    <= bytes_nxt;
    ha_r       <= ha_nxt;
    p_r        <= p_nxt;
    i_r        <= i_nxt;
    hole_r     <= hole_nxt;
    slot_r     <= slot_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (own_we) begin
      owner_mem[slot_r] <= key_r;
    end
    owner_rd_r <= owner_mem[victim_r];
  end

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status != hfsc_pkg::STATUS_OK)
      |-> (out_item.slot_index == 3'd0 && !out_item.was_hit))
    else $error("error result carries a slot or a hit flag");

  a_zero_addr_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_addr == '0)
      |=> (out_strobe && out_item.status == hfsc_pkg::STATUS_ADDR_ZERO))
    else $error("zero address request did not answer in the next cycle");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while the sequencer is still busy");

  a_victim_range: assert property (@(posedge clk) disable iff (!rst_n)
    victim_r <= SW'(SLOT_COUNT - 1))
    else $error("victim pointer out of range");

endmodule

FILE: sim/tb_hashed_frame_slot_cache_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the hashed frame slot cache core, with its own slot table predictor.
module tb_hashed_frame_slot_cache_core;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 120;
  localparam int BUCKETS      = 16;
  localparam int SLOTS        = 8;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  hfsc_pkg::in_item_t  in_item;
  logic                out_strobe;
  hfsc_pkg::out_item_t out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [15:0]         cfg_data;

  logic [31:0] bucket_tag [BUCKETS];
  logic [2:0]  bucket_owner_slot [BUCKETS];
  logic [31:0] slot_frame [SLOTS];
  logic [2:0]  victim;
  logic [15:0] capacity;

  hfsc_pkg::out_item_t slot_replies_due[$];

  int fail_count   = 0;
  int items_sent   = 0;
  int replies_seen = 0;
  int hit_count    = 0;
  int load_count   = 0;
  int reject_count = 0;
  int cap_writes   = 0;
  int cycle_count;

  hashed_frame_slot_cache_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [3:0] home_of(logic [31:0] a);
    logic [31:0] x;
    x = a ^ (a >> 16);
    x = x * hfsc_pkg::HASH_MULT;
    x = x ^ (x >> 16);
    return x[3:0];
  endfunction

  function automatic bit find_frame(input logic [31:0] a, output logic [2:0] slot);
    logic [3:0] p;
    p = home_of(a);
    slot = '0;
    for (int i = 0; i < BUCKETS; i++) begin
      if (bucket_tag[p] == a) begin
        slot = bucket_owner_slot[p];
        return 1'b1;
      end
      if (bucket_tag[p] == '0) return 1'b0;
      p = p + 4'd1;
    end
    return 1'b0;
  endfunction

  function automatic void drop_frame(logic [31:0] a);
    logic [3:0] p;
    logic [3:0] hole;
    logic [3:0] q;
    logic [3:0] nh;
    logic [3:0] hole_span;
    logic [3:0] entry_span;
    bit         found;
    p = home_of(a);
    found = 1'b0;
    for (int i = 0; i < BUCKETS; i++) begin
      if (bucket_tag[p] == a) begin
        found = 1'b1;
        break;
      end
      if (bucket_tag[p] == '0) break;
      p = p + 4'd1;
    end
    if (!found) return;
    bucket_tag[p] = '0;
    bucket_owner_slot[p] = '0;
    hole = p;
    q = p;
    for (int i = 1; i < BUCKETS; i++) begin
      q = q + 4'd1;
      if (bucket_tag[q] == '0) break;
      nh = home_of(bucket_tag[q]);
      hole_span = hole - nh;
      entry_span = q - nh;
      if (hole_span < entry_span) begin
        bucket_tag[hole] = bucket_tag[q];
        bucket_owner_slot[hole] = bucket_owner_slot[q];
        bucket_tag[q] = '0;
        bucket_owner_slot[q] = '0;
        hole = q;
      end
    end
  endfunction

  function automatic void place_frame(logic [31:0] a, logic [2:0] slot);
    logic [3:0] p;
    p = home_of(a);
    for (int i = 0; i < BUCKETS; i++) begin
      if (bucket_tag[p] == a || bucket_tag[p] == '0) begin
        bucket_tag[p] = a;
        bucket_owner_slot[p] = slot;
        return;
      end
      p = p + 4'd1;
    end
  endfunction

  function automatic hfsc_pkg::out_item_t resolve_frame(hfsc_pkg::in_item_t req);
    hfsc_pkg::out_item_t r;
    logic [2:0]          s;
    logic [31:0]         old;
    r = '0;
    if (req.frame_address == '0) begin
      r.status = hfsc_pkg::STATUS_ADDR_ZERO;
      return r;
    end
    if (find_frame(req.frame_address, s)) begin
      r.slot_index = s;
      r.was_hit = 1'b1;
      r.status = hfsc_pkg::STATUS_OK;
      return r;
    end
    if (req.frame_bytes > capacity) begin
      r.status = hfsc_pkg::STATUS_TOO_LARGE;
      return r;
    end
    s = victim;
    victim = victim + 3'd1;
    old = slot_frame[s];
    if (old != '0) drop_frame(old);
    place_frame(req.frame_address, s);
    slot_frame[s] = req.frame_address;
    r.slot_index = s;
    r.status = hfsc_pkg::STATUS_OK;
    return r;
  endfunction

  function automatic logic [31:0] fresh_addr();
    logic [31:0] a;
    a = $urandom;
    while (a == '0) a = $urandom;
    return a;
  endfunction

  function automatic logic [31:0] addr_at_home(logic [3:0] h);
    logic [31:0] a;
    a = $urandom;
    while (a == '0 || home_of(a) != h) a = $urandom;
    return a;
  endfunction

  function automatic logic [15:0] pick_bytes();
    int          r;
    logic [15:0] b;
    r = $urandom_range(0, 99);
    if (r < 70) b = 16'($urandom_range(0, capacity));
    else if (r < 85) b = 16'($urandom);
    else if (r < 93) b = (capacity == 16'hFFFF) ? capacity : capacity + 16'd1;
    else b = 16'hFFFF;
    return b;
  endfunction

  task automatic request_frame(logic [31:0] addr, logic [15:0] bytes);
    hfsc_pkg::in_item_t  req;
    hfsc_pkg::out_item_t ans;
    req.frame_address = addr;
    req.frame_bytes = bytes;
    @(negedge clk);
    start <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy);
    ans = resolve_frame(req);
    slot_replies_due.push_back(ans);
    items_sent++;
    if (ans.status != hfsc_pkg::STATUS_OK) reject_count++;
    else if (ans.was_hit) hit_count++;
    else load_count++;
  endtask

  task automatic pause_sender(int cycles);
    if (cycles == 0) return;
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) pause_sender(0);
    else if (r < 85) pause_sender($urandom_range(1, 3));
    else if (r < 97) pause_sender($urandom_range(4, 10));
    else pause_sender($urandom_range(20, 60));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (slot_replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(logic [15:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    capacity = value;
    cap_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_address_zero();
    request_frame(32'h0, 16'h0);
    random_gap();
    request_frame(32'h0, 16'hFFFF);
  endtask

  task automatic test_cluster_shift();
    logic [31:0] cluster [5];
    logic [31:0] n1;
    logic [31:0] n2;
    for (int i = 0; i < 5; i++) cluster[i] = addr_at_home(4'd15);
    n1 = addr_at_home(4'd0);
    n2 = addr_at_home(4'd1);
    for (int i = 0; i < 5; i++) request_frame(cluster[i], 16'd64);
    for (int i = 0; i < 3; i++) request_frame(fresh_addr(), 16'd64);
    request_frame(n1, 16'd0);
    request_frame(cluster[4], 16'hFFFF);
    request_frame(cluster[1], 16'd0);
    request_frame(n2, 16'd1);
    request_frame(cluster[4], 16'd0);
    request_frame(n1, 16'd0);
  endtask

  task automatic test_size_limit();
    logic [31:0] a1;
    logic [31:0] a2;
    a1 = fresh_addr();
    a2 = fresh_addr();
    request_frame(a1, hfsc_pkg::CAP_RESET);
    request_frame(a1, 16'hFFFF);
    request_frame(a2, hfsc_pkg::CAP_RESET + 16'd1);
    request_frame(a2, 16'd0);
    request_frame(32'hFFFF_FFFF, 16'd1);
  endtask

  task automatic test_capacity_extremes();
    set_capacity(16'd0);
    request_frame(fresh_addr(), 16'd0);
    request_frame(fresh_addr(), 16'd1);
    set_capacity(16'hFFFF);
    request_frame(fresh_addr(), 16'hFFFF);
    set_capacity(16'd1);
    request_frame(fresh_addr(), 16'd1);
    request_frame(fresh_addr(), 16'd2);
  endtask

  task automatic test_random_phase(logic [15:0] cap_value, int count);
    logic [31:0] pool [12];
    logic [3:0]  hot;
    int          burst;
    int          pick;
    logic [31:0] addr;
    set_capacity(cap_value);
    hot = 4'($urandom);
    burst = 0;
    for (int i = 0; i < 12; i++) pool[i] = (i < 6) ? addr_at_home(hot) : fresh_addr();
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) addr = '0;
      else if (pick < 14) addr = fresh_addr();
      else addr = pool[$urandom_range(0, 11)];
      if ($urandom_range(0, 19) == 0) begin
        pool[$urandom_range(0, 11)] = $urandom_range(0, 1) ? addr_at_home(hot) : fresh_addr();
      end
      request_frame(addr, pick_bytes());
      if (n == count / 2) wait_drained();
      else if (burst > 0) burst--;
      else if ($urandom_range(0, 29) == 0) burst = $urandom_range(10, 30);
      else random_gap();
    end
  endtask

  always @(posedge clk) begin : check_replies
    hfsc_pkg::out_item_t want;
    if (rst_n && out_strobe) begin
      replies_seen++;
      if (slot_replies_due.size() == 0) begin
        $error("Result with none pending: slot_index %0d was_hit %0d status %0d",
               out_item.slot_index, out_item.was_hit, out_item.status);
        fail_count++;
      end else begin
        want = slot_replies_due.pop_front();
        if (out_item.slot_index !== want.slot_index) begin
          $error("slot_index expected %0d actual %0d", want.slot_index, out_item.slot_index);
          fail_count++;
        end
        if (out_item.was_hit !== want.was_hit) begin
          $error("was_hit expected %0d actual %0d", want.was_hit, out_item.was_hit);
          fail_count++;
        end
        if (out_item.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_item.status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles.", cycle_count);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    for (int i = 0; i < BUCKETS; i++) begin
      bucket_tag[i] = '0;
      bucket_owner_slot[i] = '0;
    end
    for (int i = 0; i < SLOTS; i++) slot_frame[i] = '0;
    victim = '0;
    capacity = hfsc_pkg::CAP_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_cluster_shift();
    test_address_zero();
    test_size_limit();
    test_capacity_extremes();
    test_random_phase(16'hFFFF, 160);
    test_random_phase(16'($urandom_range(1, 65535)), 160);
    test_random_phase(16'd1, 80);
    test_random_phase(hfsc_pkg::CAP_RESET, 170);
    test_random_phase(16'd0, 80);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items under %0d capacity settings: %0d hits, %0d loads, %0d rejected.",
             items_sent, cap_writes + 1, hit_count, load_count, reject_count);
    $display("Checked %0d results with %0d mismatches.", replies_seen, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/hfsc_pkg.sv
hdl/hfsc_hash.sv
hdl/hfsc_bucket_mem.sv
hdl/hashed_frame_slot_cache_core.sv
sim/tb_hashed_frame_slot_cache_core.sv
